// ===== hdl/pdrg_pkg.sv =====
// ----------------------------------------------------------------------------
// pdrg_pkg: shared types and constants of the point decimate / transform block
// Field widths, fixed-point constants, register codes and the structs that
// travel between the front end, the queue, the config unit and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package pdrg_pkg;

  localparam int COORD_W  = 32;
  localparam int STRIDE_W = 13;
  localparam int PHASE_W  = 12;
  localparam int RANGE_W  = 23;
  localparam int IDX_W    = 4;
  localparam int DATA_W   = 32;

  // stream packing
  localparam int IN_TDATA_W  = 112;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 96;

  // fixed point
  localparam int E60_W  = 65;             // Q.60 matrix entry before rounding
  localparam int MAT_W  = 34;             // Q.30 matrix entry, range -8 to just under +8
  localparam int QP_W   = 64;             // product of two Q1.30 components
  localparam int PROD_W = MAT_W + COORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SQ1_W  = 2 * COORD_W;
  localparam int SQ_W   = SQ1_W + 2;
  localparam int LIM_W  = 2 * RANGE_W;
  localparam int RES_W  = SUM_W - 30 + 1;

  localparam logic signed [COORD_W-1:0] Q30_ONE = 32'sd1073741824;
  localparam logic signed [COORD_W-1:0] Q30_NEG = -32'sd1073741824;
  localparam logic signed [E60_W-1:0]   ONE_Q60 = E60_W'(1) <<< 60;
  localparam logic signed [E60_W-1:0]   HALF_Q30_E = E60_W'(1) <<< 29;
  localparam logic signed [SUM_W-1:0]   HALF_Q30_S = SUM_W'(1) <<< 29;

  localparam logic [STRIDE_W-1:0] STRIDE_ONE = 13'd1;
  localparam logic [STRIDE_W-1:0] STRIDE_MAX = 13'd4096;
  localparam logic [RANGE_W-1:0]  RANGE_MIN  = 23'd65536;
  localparam logic [RANGE_W-1:0]  RANGE_MAX  = 23'd5242880;
  localparam logic [RANGE_W-1:0]  RANGE_RST  = 23'd1638400;

  // matrix rebuild latency after a register write
  localparam logic [1:0] SETTLE_CYC = 2'd2;

  typedef enum logic [IDX_W-1:0] {
    REG_QUAT_W  = 4'd0,
    REG_QUAT_X  = 4'd1,
    REG_QUAT_Y  = 4'd2,
    REG_QUAT_Z  = 4'd3,
    REG_SHIFT_X = 4'd4,
    REG_SHIFT_Y = 4'd5,
    REG_SHIFT_Z = 4'd6,
    REG_RANGE   = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] pos;   // pos[0] = x
  } point_t;

  typedef struct packed {
    logic [2:0][2:0][MAT_W-1:0] mat;    // mat[row][col], Q.30
    logic [2:0][COORD_W-1:0]    shift;  // Q15.16
    logic [LIM_W-1:0]           lim_sq; // range limit squared, Q.32
  } xform_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [COORD_W-1:0] clamp_q30(
      input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    r = v;
    if (v > Q30_ONE) r = Q30_ONE;
    if (v < Q30_NEG) r = Q30_NEG;
    return r;
  endfunction

  // round Q.60 to Q.30, half up
  function automatic logic [MAT_W-1:0] to_q30(input logic signed [E60_W-1:0] e);
    logic signed [E60_W-1:0] t;
    t = e + HALF_Q30_E;
    return t[30 +: MAT_W];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pdrg_queue.sv =====
// ----------------------------------------------------------------------------
// pdrg_queue: short point queue between front end and back end
// Register-based FIFO; the head entry is presented without a read delay.
// ----------------------------------------------------------------------------
`default_nettype none

module pdrg_queue
  import pdrg_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire point_t  push_data_i,
  input  wire logic    pop_i,
  output point_t       head_o,
  output q_stat_t      stat_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  point_t         mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pdrg_front.sv =====
// ----------------------------------------------------------------------------
// pdrg_front: input acceptance and stride decimation
// Tracks the stride phase of the scan and queues only points that are kept
// and marked valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pdrg_front
  import pdrg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                point_valid_i,
  input  wire logic [STRIDE_W-1:0] keep_every_i,
  input  wire logic                scan_start_i,
  input  wire q_stat_t             q_stat_i,
  input  wire logic                busy_i,
  output logic                     push_o
);

  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [STRIDE_W-1:0] stride, phase, nxt;
  logic                accept, keep;

  assign in_ready_o = !q_stat_i.full && !busy_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    stride = keep_every_i;
    if (keep_every_i == '0)       stride = STRIDE_ONE;
    if (keep_every_i > STRIDE_MAX) stride = STRIDE_MAX;
    phase = scan_start_i ? '0 : {1'b0, phase_q};
    // stride lowered mid-scan: restart the count
    if (phase >= stride) phase = '0;
    keep = (phase == '0);
    nxt  = phase + STRIDE_ONE;
    if (nxt >= stride) nxt = '0;
    phase_d = accept ? nxt[PHASE_W-1:0] : phase_q;
  end

  // dropped points still advance the phase
  assign push_o = accept && keep && point_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pdrg_cfg.sv =====
// ----------------------------------------------------------------------------
// pdrg_cfg: configuration registers and rotation matrix builder
// Holds quaternion, shift and range limit; rebuilds the Q.30 rotation matrix
// in two register stages, and the squared range limit in the first, after every write.
// ----------------------------------------------------------------------------
`default_nettype none

module pdrg_cfg
  import pdrg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [IDX_W-1:0]  index_i,
  input  wire logic [DATA_W-1:0] data_i,
  output xform_t                 xf_o,
  output logic                   busy_o
);

  logic signed [COORD_W-1:0] qw_q, qx_q, qy_q, qz_q;
  logic [2:0][COORD_W-1:0]   shift_q;
  logic [RANGE_W-1:0]        range_q;
  logic [1:0]                settle_q;

  logic signed [COORD_W-1:0] w, x, y, z;
  logic signed [QP_W-1:0]    xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [E60_W-1:0]   exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
  logic [2:0][2:0][MAT_W-1:0] mat_d, mat_q;
  logic [RANGE_W-1:0]        rl;
  logic [LIM_W-1:0]          lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qw_q     <= Q30_ONE;
      qx_q     <= '0;
      qy_q     <= '0;
      qz_q     <= '0;
      shift_q  <= '0;
      range_q  <= RANGE_RST;
      settle_q <= SETTLE_CYC;
    end else begin
      if (we_i) begin
        unique case (cfg_reg_e'(index_i))
          REG_QUAT_W:  qw_q <= data_i;
          REG_QUAT_X:  qx_q <= data_i;
          REG_QUAT_Y:  qy_q <= data_i;
          REG_QUAT_Z:  qz_q <= data_i;
          REG_SHIFT_X: shift_q[0] <= data_i;
          REG_SHIFT_Y: shift_q[1] <= data_i;
          REG_SHIFT_Z: shift_q[2] <= data_i;
          REG_RANGE:   range_q <= data_i[RANGE_W-1:0];
          default: ;
        endcase
        settle_q <= SETTLE_CYC;
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 1'b1;
      end
    end
  end

  assign w = clamp_q30(qw_q);
  assign x = clamp_q30(qx_q);
  assign y = clamp_q30(qy_q);
  assign z = clamp_q30(qz_q);

  always_comb begin
    rl = range_q;
    if (range_q < RANGE_MIN) rl = RANGE_MIN;
    if (range_q > RANGE_MAX) rl = RANGE_MAX;
  end

  // stage 1: component products
  always_ff @(posedge clk_i) begin
    xx_q  <= QP_W'(x) * QP_W'(x);
    yy_q  <= QP_W'(y) * QP_W'(y);
    zz_q  <= QP_W'(z) * QP_W'(z);
    xy_q  <= QP_W'(x) * QP_W'(y);
    xz_q  <= QP_W'(x) * QP_W'(z);
    yz_q  <= QP_W'(y) * QP_W'(z);
    wx_q  <= QP_W'(w) * QP_W'(x);
    wy_q  <= QP_W'(w) * QP_W'(y);
    wz_q  <= QP_W'(w) * QP_W'(z);
    lim_q <= LIM_W'(rl) * LIM_W'(rl);
  end

  assign exx = E60_W'(xx_q);
  assign eyy = E60_W'(yy_q);
  assign ezz = E60_W'(zz_q);
  assign exy = E60_W'(xy_q);
  assign exz = E60_W'(xz_q);
  assign eyz = E60_W'(yz_q);
  assign ewx = E60_W'(wx_q);
  assign ewy = E60_W'(wy_q);
  assign ewz = E60_W'(wz_q);

  // stage 2: matrix entries in Q.60, rounded to Q.30
  always_comb begin
    mat_d[0][0] = to_q30(ONE_Q60 - ((eyy + ezz) <<< 1));
    mat_d[0][1] = to_q30((exy - ewz) <<< 1);
    mat_d[0][2] = to_q30((exz + ewy) <<< 1);
    mat_d[1][0] = to_q30((exy + ewz) <<< 1);
    mat_d[1][1] = to_q30(ONE_Q60 - ((exx + ezz) <<< 1));
    mat_d[1][2] = to_q30((eyz - ewx) <<< 1);
    mat_d[2][0] = to_q30((exz - ewy) <<< 1);
    mat_d[2][1] = to_q30((eyz + ewx) <<< 1);
    mat_d[2][2] = to_q30(ONE_Q60 - ((exx + eyy) <<< 1));
  end

  always_ff @(posedge clk_i) begin
    mat_q <= mat_d;
  end

  assign xf_o.mat    = mat_q;
  assign xf_o.shift  = shift_q;
  assign xf_o.lim_sq = lim_q;
  assign busy_o      = (settle_q != '0);

endmodule

`default_nettype wire

// ===== hdl/pdrg_back.sv =====
// ----------------------------------------------------------------------------
// pdrg_back: range gate and rigid transform pipeline
// Three stages: products, row sums with range compare, shift and saturate.
// The last stage is the output register; the whole pipe holds on a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module pdrg_back
  import pdrg_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire xform_t  xf_i,
  input  wire point_t  head_i,
  input  wire q_stat_t q_stat_i,
  output logic         pop_o,
  output logic         res_valid_o,
  input  wire logic    res_ready_i,
  output point_t       res_o
);

  logic                     en;
  logic                     v1_q, v2_q, v3_q;
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic [SQ1_W-1:0]         sq_q [3];
  logic signed [SUM_W-1:0]  sum_q [3];
  logic                     inr_q;
  point_t                   res_q, res_d;
  logic [COORD_W-1:0]       mag [3];
  logic signed [RES_W-1:0]  tot [3];

  assign en    = !(v3_q && !res_ready_i);
  assign pop_o = en && !q_stat_i.empty;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = head_i.pos[i][COORD_W-1] ? (~head_i.pos[i] + 1'b1) : head_i.pos[i];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tot[r] = RES_W'($signed(sum_q[r][SUM_W-1:30])) + RES_W'($signed(xf_i.shift[r]));
      if (tot[r][RES_W-1:COORD_W-1] == '0 || tot[r][RES_W-1:COORD_W-1] == '1) begin
        res_d.pos[r] = tot[r][COORD_W-1:0];
      end else if (tot[r][RES_W-1]) begin
        res_d.pos[r] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        res_d.pos[r] = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      // drop points beyond the range limit
      v3_q <= v2_q && inr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[r][i] <= PROD_W'($signed(xf_i.mat[r][i]))
                        * PROD_W'($signed(head_i.pos[i]));
        end
        sum_q[r] <= SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1])
                  + SUM_W'(prod_q[r][2]) + HALF_Q30_S;
      end
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SQ1_W'(mag[i]) * SQ1_W'(mag[i]);
      end
      inr_q <= (SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]))
               <= SQ_W'(xf_i.lim_sq);
      res_q <= res_d;
    end
  end

  assign res_valid_o = v3_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== hdl/point_decimate_range_gate_transform.sv =====
// ----------------------------------------------------------------------------
// point_decimate_range_gate_transform: lidar point decimator and transform
// Keeps every stride-th point of a scan, gates by validity and range, then
// rotates by a Q1.30 quaternion, translates and saturates to Q15.16.
// ----------------------------------------------------------------------------
// One point is accepted every clock while the point queue has room and the
// config unit is not busy. A kept point is written into the point queue,
// then passes the product stage, the row-sum and range-compare stage, and
// lands in the output register. The input closes after reset and after each
// configuration write, while the config unit rebuilds the rotation matrix
// in its two register stages and the squared range limit in the first.
// A stalled output fills the queue of QUEUE_DEPTH points before the input
// closes.
`default_nettype none

module point_decimate_range_gate_transform
  import pdrg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], keep_every[108:96], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // point_valid[0], scan_start[1]
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [IDX_W-1:0]       cfg_index_i,
  input  wire logic [DATA_W-1:0]      cfg_data_i
);

  point_t  in_pt, head, res;
  q_stat_t q_stat;
  xform_t  xf;
  logic    busy, q_push, q_pop, cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign in_pt.pos[0] = s_axis_tdata[31:0];
  assign in_pt.pos[1] = s_axis_tdata[63:32];
  assign in_pt.pos[2] = s_axis_tdata[95:64];

  pdrg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .xf_o    (xf),
    .busy_o  (busy)
  );

  pdrg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .point_valid_i (s_axis_tuser[0]),
    .keep_every_i  (s_axis_tdata[108:96]),
    .scan_start_i  (s_axis_tuser[1]),
    .q_stat_i      (q_stat),
    .busy_i        (busy),
    .push_o        (q_push)
  );

  pdrg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (in_pt),
    .pop_i       (q_pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  pdrg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .xf_i        (xf),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = res.pos;

  // no point may enter while the matrix is being rebuilt
  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready)
    else $error("input open right after a configuration write");

  a_full_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !s_axis_tready)
    else $error("input open while the point queue is full");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full || q_pop)
    else $error("point pushed into a full queue");

endmodule

`default_nettype wire

// ===== tb/tb_point_decimate_range_gate_transform.sv =====
// ----------------------------------------------------------------------------
// tb_point_decimate_range_gate_transform: self-checking bench for the lidar
// point decimator, range gate and rigid transform.
// Drives points on the input stream and checks every output point against an
// in-bench predictor of stride, gating, rotation and saturation. Runs
// directed corner points, register extremes, a long output hold, and random
// scans under several idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_decimate_range_gate_transform;
  import pdrg_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no transfer anywhere
  localparam int DRAIN_CYC   = 8;
  localparam int HOLD_CYC    = 120;
  localparam logic [IDX_W-1:0] REG_SPARE_A = 4'd8;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 4'd15;
  localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;
  localparam logic signed [31:0] METER = 32'sd65536;

  typedef struct packed {
    logic               start;
    logic               valid;
    logic [12:0]        stride;
    logic signed [31:0] pz;
    logic signed [31:0] py;
    logic signed [31:0] px;
  } lidar_pt_t;

  // x in the low bits, as on the output tdata
  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } xyz_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [IDX_W-1:0]       cfg_index_i;
  logic [DATA_W-1:0]      cfg_data_i;

  // predictor state and register copies
  logic signed [31:0] quat_m [4];    // w, x, y, z
  logic signed [31:0] shift_m [3];
  logic [22:0]        range_m;
  logic [11:0]        stride_pos;

  xyz_t pending_pts [$];
  xyz_t got_pt, want_pt;
  int   err_cnt = 0;
  int   idle_cnt = 0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  bit   hold_req = 1'b0;
  int   scan_left = 0;
  logic [12:0] scan_stride = 13'd1;

  point_decimate_range_gate_transform u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [22:0] clamped_range();
    logic [22:0] rl;
    rl = range_m;
    if (rl < RANGE_MIN) rl = RANGE_MIN;
    if (rl > RANGE_MAX) rl = RANGE_MAX;
    return rl;
  endfunction

  function automatic logic signed [63:0] unit_clamp(input logic signed [31:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > 32'sd1073741824) r = 64'sd1073741824;
    if (v < -32'sd1073741824) r = -64'sd1073741824;
    return r;
  endfunction

  // Q.60 to Q.30, round half up
  function automatic logic signed [63:0] q30_round(input logic signed [63:0] e60);
    return (e60 + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [31:0] rotate_row(
      input logic signed [63:0] a, b, c,
      input logic signed [31:0] x, y, z, sh);
    logic signed [127:0] acc;
    acc = a * x + b * y + c * z;
    acc = ((acc + 128'sd536870912) >>> 30) + sh;
    if (acc > 128'sd2147483647) acc = 128'sd2147483647;
    else if (acc < -128'sd2147483648) acc = -128'sd2147483648;
    return acc[31:0];
  endfunction

  // Advance the stride phase; return 1 and the transformed point if kept.
  function automatic bit transform_point(input lidar_pt_t p, output xyz_t res);
    logic [12:0] k, ph, nx;
    logic signed [66:0] sq, lim, cv;
    logic signed [63:0] qw, qx, qy, qz, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [63:0] rot [9];
    logic signed [31:0] cc [3];
    int i;
    res = '0;
    k = p.stride;
    ph = p.start ? 13'd0 : {1'b0, stride_pos};
    if (k == 13'd0) k = STRIDE_ONE;
    if (k > STRIDE_MAX) k = STRIDE_MAX;
    if (ph >= k) ph = 13'd0;
    nx = ph + 13'd1;
    if (nx >= k) nx = 13'd0;
    stride_pos = nx[11:0];
    if (ph != 13'd0 || !p.valid) return 1'b0;

    cc[0] = p.px;
    cc[1] = p.py;
    cc[2] = p.pz;
    sq = '0;
    for (i = 0; i < 3; i++) begin
      cv = cc[i];
      sq = sq + cv * cv;
    end
    lim = clamped_range();
    lim = lim * lim;
    if (sq > lim) return 1'b0;

    qw = unit_clamp(quat_m[0]);
    qx = unit_clamp(quat_m[1]);
    qy = unit_clamp(quat_m[2]);
    qz = unit_clamp(quat_m[3]);
    xx = qx * qx; yy = qy * qy; zz = qz * qz;
    xy = qx * qy; xz = qx * qz; yz = qy * qz;
    wx = qw * qx; wy = qw * qy; wz = qw * qz;
    rot[0] = q30_round(ONE_Q60 - 2 * (yy + zz));
    rot[1] = q30_round(2 * (xy - wz));
    rot[2] = q30_round(2 * (xz + wy));
    rot[3] = q30_round(2 * (xy + wz));
    rot[4] = q30_round(ONE_Q60 - 2 * (xx + zz));
    rot[5] = q30_round(2 * (yz - wx));
    rot[6] = q30_round(2 * (xz - wy));
    rot[7] = q30_round(2 * (yz + wx));
    rot[8] = q30_round(ONE_Q60 - 2 * (xx + yy));
    res.x = rotate_row(rot[0], rot[1], rot[2], cc[0], cc[1], cc[2], shift_m[0]);
    res.y = rotate_row(rot[3], rot[4], rot[5], cc[0], cc[1], cc[2], shift_m[1]);
    res.z = rotate_row(rot[6], rot[7], rot[8], cc[0], cc[1], cc[2], shift_m[2]);
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------ drivers

  task automatic send_point(input lidar_pt_t p);
    xyz_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, p.stride, p.pz, p.py, p.px};
    s_axis_tuser  <= {p.start, p.valid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (transform_point(p, r)) pending_pts.insert(pending_pts.size(), r);
    @(negedge clk_i);
  endtask

  // Leaves cfg_valid_i high; close_cfg drops it.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_QUAT_W:  quat_m[0] = val;
      REG_QUAT_X:  quat_m[1] = val;
      REG_QUAT_Y:  quat_m[2] = val;
      REG_QUAT_Z:  quat_m[3] = val;
      REG_SHIFT_X: shift_m[0] = val;
      REG_SHIFT_Y: shift_m[1] = val;
      REG_SHIFT_Z: shift_m[2] = val;
      REG_RANGE:   range_m = val[22:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic close_cfg();
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic [31:0] w, x, y, z, sx, sy, sz, rng);
    write_reg(REG_QUAT_W, w);
    write_reg(REG_QUAT_X, x);
    write_reg(REG_QUAT_Y, y);
    write_reg(REG_QUAT_Z, z);
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_SHIFT_Z, sz);
    write_reg(REG_RANGE, rng);
    close_cfg();
  endtask

  // Drop the input, let every expected point arrive, then cover dropped
  // points still in flight.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic lidar_pt_t mk_pt(input logic signed [31:0] x, y, z,
                                      input logic valid, input logic [12:0] stride,
                                      input logic start);
    lidar_pt_t p;
    p.px = x; p.py = y; p.pz = z;
    p.valid = valid; p.stride = stride; p.start = start;
    return p;
  endfunction

  function automatic logic [31:0] rand_coord(input int span);
    return $urandom_range(2 * span, 0) - span;
  endfunction

  function automatic logic [31:0] rand_quat();
    case ($urandom_range(9))
      0: return 32'h4000_0000;
      1: return 32'hC000_0000;
      2: return $urandom;
      default: return $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_shift();
    if ($urandom_range(4) == 0) return $urandom;
    return $urandom_range(200 * 65536, 0) - 100 * 65536;
  endfunction

  function automatic logic [31:0] rand_range();
    case ($urandom_range(9))
      0: return $urandom_range(65535, 0);
      1: return $urandom;
      default: return $urandom_range(RANGE_MAX, RANGE_MIN);
    endcase
  endfunction

  // Mostly well-formed scans; some stride changes mid-scan and stray noise.
  function automatic lidar_pt_t random_point();
    lidar_pt_t p;
    int span, lim_c;
    span = clamped_range() / 2;
    p.start = 1'b0;
    if (scan_left == 0) begin
      scan_left = $urandom_range(40, 4);
      p.start = 1'b1;
      case ($urandom_range(19))
        0: scan_stride = 13'd0;
        1: scan_stride = 13'($urandom_range(8191, 4096));
        2, 3: scan_stride = 13'($urandom_range(16, 5));
        default: scan_stride = 13'($urandom_range(4, 1));
      endcase
    end else if ($urandom_range(19) == 0) begin
      scan_stride = 13'($urandom_range(3, 1));
    end
    scan_left--;
    p.stride = scan_stride;
    if ($urandom_range(32) == 0) begin
      p.start = 1'($urandom_range(1));
      p.stride = 13'($urandom);
    end
    p.valid = ($urandom_range(9) != 0);
    case ($urandom_range(19))
      14, 15, 16, 17: begin
        // on the range limit, or one step either side
        lim_c = clamped_range() + $urandom_range(2) - 1;
        p.px = $urandom_range(1) ? lim_c : -lim_c;
        p.py = 32'sd0;
        p.pz = 32'sd0;
        if ($urandom_range(1)) begin
          p.pz = p.px;
          p.px = 32'sd0;
        end
      end
      18, 19: begin
        p.px = $urandom;
        p.py = $urandom;
        p.pz = $urandom;
      end
      default: begin
        p.px = rand_coord(span);
        p.py = rand_coord(span);
        p.pz = rand_coord(span);
      end
    endcase
    return p;
  endfunction

  // ------------------------------------------------------------------- tests

  // Reset setting: identity, no shift, 25 m range.
  task automatic test_gate_and_stride();
    send_point(mk_pt(32'sd0, 32'sd0, 32'sd0, 1'b1, 13'd1, 1'b1));
    send_point(mk_pt(32'sd1638400, 32'sd0, 32'sd0, 1'b1, 13'd1, 1'b0));
    send_point(mk_pt(-32'sd1638401, 32'sd0, 32'sd0, 1'b1, 13'd1, 1'b0));
    send_point(mk_pt(32'sd65536, 32'sd131072, -32'sd65536, 1'b0, 13'd1, 1'b0));
    send_point(mk_pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 13'd1, 1'b0));
    // zero stride behaves as one
    send_point(mk_pt(32'sd100000, -32'sd200000, 32'sd300000, 1'b1, 13'd0, 1'b0));
    send_point(mk_pt(-32'sd100000, 32'sd200000, -32'sd300000, 1'b1, 13'd0, 1'b0));
    // oversize stride saturates at the maximum
    send_point(mk_pt(32'sd7, 32'sd8, 32'sd9, 1'b1, 13'h1FFF, 1'b1));
    send_point(mk_pt(32'sd7, 32'sd8, 32'sd9, 1'b1, 13'h1FFF, 1'b0));
    // stride lowered mid-scan restarts the phase
    send_point(mk_pt(32'sd1, 32'sd2, 32'sd3, 1'b1, 13'd4, 1'b1));
    send_point(mk_pt(32'sd4, 32'sd5, 32'sd6, 1'b1, 13'd4, 1'b0));
    send_point(mk_pt(32'sd7, 32'sd8, 32'sd9, 1'b1, 13'd4, 1'b0));
    send_point(mk_pt(32'sd10, 32'sd11, 32'sd12, 1'b1, 13'd2, 1'b0));
    // a new scan restarts the count
    send_point(mk_pt(32'sd20, 32'sd21, 32'sd22, 1'b1, 13'd3, 1'b1));
    send_point(mk_pt(32'sd23, 32'sd24, 32'sd25, 1'b1, 13'd3, 1'b1));
  endtask

  task automatic test_register_extremes();
    wait_idle();
    // components clamp to +1, shifts at both rails, range clamps to 1 m
    apply_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    send_point(mk_pt(32'sd0, 32'sd0, METER, 1'b1, 13'd1, 1'b1));
    send_point(mk_pt(-METER, 32'sd0, 32'sd0, 1'b1, 13'd1, 1'b0));
    wait_idle();
    // range register upper bits masked, clamps to 80 m
    apply_setting(32'h8000_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'hC000_0000,
                  32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_point(mk_pt(32'sd5242880, 32'sd0, 32'sd0, 1'b1, 13'd1, 1'b0));
    send_point(mk_pt(32'sd4000000, 32'sd4000000, 32'sd0, 1'b1, 13'd1, 1'b0));
    wait_idle();
    apply_setting(32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000,
                  32'hFFFB_0000, 32'h00C8_0000, 32'h7FFF_0000, RANGE_MAX);
    send_point(mk_pt(32'sd655360, -32'sd1310720, 32'sd229376, 1'b1, 13'd1, 1'b0));
    wait_idle();
    // writes to unused indexes leave the setting alone
    write_reg(REG_SPARE_A, 32'h0000_0000);
    write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
    close_cfg();
    send_point(mk_pt(32'sd655360, -32'sd1310720, 32'sd229376, 1'b1, 13'd1, 1'b0));
  endtask

  // Hold the output off while points keep coming so the input backs up.
  task automatic test_output_hold();
    int i;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_req = 1'b1;
    for (i = 0; i < 30; i++)
      send_point(mk_pt(rand_coord(600000), rand_coord(600000), rand_coord(600000),
                       1'b1, 13'd1, i == 0));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int src_mix [4]  = '{0, 77, 0, 24};
    int sink_mix [4] = '{0, 0, 77, 24};
    int ph, i;
    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct = src_mix[ph];
      sink_stall_pct = sink_mix[ph];
      repeat (3) begin
        wait_idle();
        apply_setting(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                      rand_shift(), rand_shift(), rand_shift(), rand_range());
        for (i = 0; i < 92; i++) send_point(random_point());
      end
    end
  endtask

  // ------------------------------------------------------- receiver, checker

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic log_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_pt = m_axis_tdata;
      if (pending_pts.size() == 0) begin
        log_error($sformatf("unexpected output transfer %h", m_axis_tdata));
      end else begin
        want_pt = pending_pts.pop_front();
        if (got_pt.x !== want_pt.x)
          log_error($sformatf("out_x: expected %h got %h", want_pt.x, got_pt.x));
        if (got_pt.y !== want_pt.y)
          log_error($sformatf("out_y: expected %h got %h", want_pt.y, got_pt.y));
        if (got_pt.z !== want_pt.z)
          log_error($sformatf("out_z: expected %h got %h", want_pt.z, got_pt.z));
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // -------------------------------------------------------------------- main

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    quat_m[0]  = Q30_ONE;
    quat_m[1]  = '0;
    quat_m[2]  = '0;
    quat_m[3]  = '0;
    shift_m[0] = '0;
    shift_m[1] = '0;
    shift_m[2] = '0;
    range_m    = RANGE_RST;
    stride_pos = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_gate_and_stride();
    test_register_extremes();
    test_output_hold();
    test_random_traffic();
    wait_idle();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
